/* sv/fps_pkg.sv */
`timescale 1ns / 1ps
// fps_pkg: shared types, constants and helpers of the flash phase sync core
// no dependencies

package fps_pkg;

  localparam int unsigned PhaseW = 12;
  localparam int unsigned CountW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StepW  = 9;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned IdxW   = 3;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  localparam logic [ByteW-1:0]  Hdr0     = 8'hAA;
  localparam logic [ByteW-1:0]  Hdr1     = 8'h55;
  localparam logic [PhaseW-1:0] MinCycle = 12'd256;

  localparam logic [PhaseW-1:0] RstCycleLength   = 12'd900;
  localparam logic [PhaseW-1:0] RstLedOnTime     = 12'd100;
  localparam logic [PhaseW-1:0] RstTxWindowStart = 12'd450;
  localparam logic [PhaseW-1:0] RstTxWindowLen   = 12'd50;
  localparam logic [ByteW-1:0]  RstTxDelayComp   = 8'd6;
  localparam logic [ByteW-1:0]  RstErrBand       = 8'd5;
  localparam logic [ByteW-1:0]  RstMaxStep       = 8'd20;

  typedef enum logic [IdxW-1:0] {
    REG_CYCLE_LENGTH     = 3'd0,
    REG_LED_ON_TIME      = 3'd1,
    REG_TX_WINDOW_START  = 3'd2,
    REG_TX_WINDOW_LENGTH = 3'd3,
    REG_TX_DELAY_COMP    = 3'd4,
    REG_ERR_BAND         = 3'd5,
    REG_MAX_STEP         = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_RX_OK  = 2'd1,
    CMD_RX_BAD = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [PhaseW-1:0] cycle_length;
    logic [PhaseW-1:0] led_on_time;
    logic [PhaseW-1:0] tx_window_start;
    logic [PhaseW-1:0] tx_window_length;
    logic [ByteW-1:0]  tx_delay_comp;
    logic [ByteW-1:0]  err_band;
    logic [ByteW-1:0]  max_step;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ByteW-1:0]  elapsed;
    logic [PhaseW-1:0] rx_phase;
  } cmd_t;

  typedef struct packed {
    logic                    lamp_on;
    logic                    tx_valid;
    logic [PhaseW-1:0]       tx_phase;
    logic [PhaseW-1:0]       cur_phase;
    logic                    rx_accepted;
    logic signed [StepW-1:0] phase_step;
  } res_t;

  // short cycle lengths behave as the minimum
  function automatic logic [PhaseW-1:0] eff_cycle(input logic [PhaseW-1:0] len);
    return (len < MinCycle) ? MinCycle : len;
  endfunction

endpackage

/* sv/fps_front.sv */
`timescale 1ns / 1ps
// fps_front: takes input items and sorts them into ticks, good and bad packets
// depends on fps_pkg

module fps_front (
  input  fps_pkg::cfg_t             cfg,
  input  logic                      push,
  input  logic                      operation,
  input  logic [fps_pkg::ByteW-1:0] elapsed_ms,
  input  logic [fps_pkg::ByteW-1:0] rx_byte0,
  input  logic [fps_pkg::ByteW-1:0] rx_byte1,
  input  logic [fps_pkg::ByteW-1:0] rx_byte2,
  input  logic [fps_pkg::ByteW-1:0] rx_byte3,
  input  logic                      q_full,
  output logic                      full,
  output logic                      q_push,
  output fps_pkg::cmd_t             cmd
);
  import fps_pkg::*;

  logic              hdr_ok;
  logic              range_ok;
  logic [PhaseW-1:0] rx_low;

  assign full   = q_full;
  assign q_push = push && !q_full;

  assign rx_low   = {rx_byte2[3:0], rx_byte3};
  assign hdr_ok   = (rx_byte0 == Hdr0) && (rx_byte1 == Hdr1);
  // a 16-bit phase must fit 12 bits and stay below the cycle length
  assign range_ok = (rx_byte2[7:4] == 4'd0) && (rx_low < eff_cycle(cfg.cycle_length));

  always_comb begin
    cmd.elapsed  = elapsed_ms;
    cmd.rx_phase = rx_low;
    if (!operation) begin
      cmd.kind = CMD_TICK;
    end else if (hdr_ok && range_ok) begin
      cmd.kind = CMD_RX_OK;
    end else begin
      cmd.kind = CMD_RX_BAD;
    end
  end

endmodule

/* sv/fps_cmd_queue.sv */
`timescale 1ns / 1ps
// fps_cmd_queue: short queue of classified items between front and back
// depends on fps_pkg

module fps_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fps_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output fps_pkg::cmd_t dout
);
  import fps_pkg::*;

  cmd_t               entries [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr;
  logic [CmdPtrW-1:0] rd_ptr;
  logic [CmdCntW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CmdCntW'(CmdDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CmdCntW'(CmdDepth))
    else $error("command queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CmdCntW'(CmdDepth)) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree with count");

endmodule

/* sv/fps_back.sv */
`timescale 1ns / 1ps
// fps_back: phase, lamp and transmit state; one item per cycle, held by a
// full two-entry result buffer or a multi-wrap tick; depends on fps_pkg

module fps_back (
  input  logic          clk,
  input  logic          rst,
  input  fps_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  fps_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          empty,
  input  logic          pop,
  output fps_pkg::res_t res
);
  import fps_pkg::*;

  typedef struct packed {
    logic              lit;
    logic [PhaseW-1:0] ms;
  } lamp_t;

  function automatic lamp_t lamp_rule(input lamp_t cur, input logic [PhaseW-1:0] ph,
                                      input logic [PhaseW-1:0] on);
    lamp_t r;
    r = cur;
    if (cur.lit) begin
      if (cur.ms >= on) r.lit = 1'b0;
    end else if (ph < on) begin
      r.lit = 1'b1;
      r.ms  = '0;
    end
    return r;
  endfunction

  // state
  logic [PhaseW-1:0] phase, phase_next;
  logic [CountW-1:0] cycle_count, cycle_count_next;
  logic [CountW-1:0] last_sent, last_sent_next;
  lamp_t             lamp, lamp_next;
  logic              reducing, reducing_next;

  // output queue
  res_t res_mem [2];
  logic wr_sel, rd_sel;
  logic [1:0] out_count;
  logic res_push;
  res_t res_new;
  logic go;
  logic do_pop;

  // tick arithmetic
  logic [PhaseW-1:0] len;
  logic [ByteW-1:0]  el_add;
  logic              adv;
  logic [PhaseW:0]   total, total_wrap;
  logic              multi, once;
  logic [PhaseW-1:0] ph_tick;
  logic [CountW-1:0] cnt_inc, cnt_tick;
  logic [PhaseW:0]   lit_sum;
  logic [PhaseW-1:0] lit_sat;
  lamp_t             lamp_adv, lamp_tick;
  logic [PhaseW:0]   win_end, tx_sum, tx_wrap;
  logic              tx_hit;

  // packet arithmetic
  localparam int unsigned DW = PhaseW + 2;
  logic [PhaseW-1:0]   half;
  logic signed [DW-1:0] d0, d, negd, half_s, len_s, db_s, ms_s, mag_f, mag_b;
  logic                fwd, bwd;
  logic [ByteW-1:0]    a8;
  logic [PhaseW:0]     sum_f, sub_f, under_b;
  logic                wrap_f, low_b;
  logic [PhaseW-1:0]   ph_rx, dec_b;
  logic [CountW-1:0]   cnt_rx;
  logic signed [StepW-1:0] step_rx;
  lamp_t               lamp_rx;

  assign len     = eff_cycle(cfg.cycle_length);
  assign cnt_inc = cycle_count + 1'b1;

  // ---- tick ----
  assign adv        = reducing || (cmd.elapsed != '0);
  assign el_add     = reducing ? '0 : cmd.elapsed;
  assign total      = {1'b0, phase} + {5'b0, el_add};
  assign total_wrap = total - {1'b0, len};
  // more than one wrap left: peel one per cycle
  assign multi      = adv && (total >= {len, 1'b0});
  assign once       = total >= {1'b0, len};
  assign ph_tick    = !adv ? phase : (once ? total_wrap[PhaseW-1:0] : total[PhaseW-1:0]);
  assign cnt_tick   = (adv && once) ? cnt_inc : cycle_count;
  assign lit_sum    = {1'b0, lamp.ms} + {5'b0, cmd.elapsed};
  assign lit_sat    = (lit_sum > {1'b0, cfg.led_on_time}) ? cfg.led_on_time
                                                         : lit_sum[PhaseW-1:0];

  always_comb begin
    lamp_adv = lamp;
    if (adv) begin
      if (reducing || once) begin
        lamp_adv.lit = 1'b1;
        lamp_adv.ms  = '0;
      end else if (lamp.lit) begin
        lamp_adv.ms = lit_sat;
      end
    end
  end

  assign lamp_tick = lamp_rule(lamp_adv, ph_tick, cfg.led_on_time);
  assign win_end   = {1'b0, cfg.tx_window_start} + {1'b0, cfg.tx_window_length};
  assign tx_hit    = (cnt_tick != last_sent) && (ph_tick >= cfg.tx_window_start) &&
                     ({1'b0, ph_tick} < win_end);
  assign tx_sum    = {1'b0, ph_tick} + {5'b0, cfg.tx_delay_comp};
  assign tx_wrap   = (tx_sum >= {1'b0, len}) ? tx_sum - {1'b0, len} : tx_sum;

  // ---- received packet ----
  assign half   = len >> 1;
  assign half_s = $signed({2'b00, half});
  assign len_s  = $signed({2'b00, len});
  assign db_s   = $signed({6'b0, cfg.err_band});
  assign ms_s   = $signed({6'b0, cfg.max_step});
  assign d0     = $signed({2'b00, cmd.rx_phase}) - $signed({2'b00, phase});
  // shortest way round
  assign d      = (d0 >= half_s) ? d0 - len_s : ((d0 < -half_s) ? d0 + len_s : d0);
  assign negd   = -d;
  assign fwd    = (d > db_s) && (cfg.max_step != '0);
  assign bwd    = (d < -db_s) && (cfg.max_step != '0);
  assign mag_f  = (d > ms_s) ? ms_s : d;
  assign mag_b  = (negd > ms_s) ? ms_s : negd;
  assign a8     = fwd ? mag_f[ByteW-1:0] : mag_b[ByteW-1:0];

  assign sum_f   = {1'b0, phase} + {5'b0, a8};
  assign sub_f   = sum_f - {1'b0, len};
  assign wrap_f  = sum_f >= {1'b0, len};
  assign low_b   = phase <= {4'b0, a8};
  // backward past zero lands at len minus the remainder
  assign under_b = {1'b0, len} - {5'b0, a8} + {1'b0, phase};
  assign dec_b   = phase - {4'b0, a8};

  always_comb begin
    ph_rx   = phase;
    cnt_rx  = cycle_count;
    step_rx = '0;
    if (fwd) begin
      ph_rx   = wrap_f ? sub_f[PhaseW-1:0] : sum_f[PhaseW-1:0];
      cnt_rx  = wrap_f ? cnt_inc : cycle_count;
      step_rx = $signed({1'b0, a8});
    end else if (bwd) begin
      ph_rx   = low_b ? under_b[PhaseW-1:0] : dec_b;
      cnt_rx  = (low_b && cycle_count != '0) ? cycle_count - 1'b1 : cycle_count;
      step_rx = -$signed({1'b0, a8});
    end
  end

  assign lamp_rx = lamp_rule(lamp, ph_rx, cfg.led_on_time);

  // ---- control ----
  assign go     = cmd_valid && (out_count != 2'd2);
  assign do_pop = pop && (out_count != 2'd0);

  always_comb begin
    phase_next       = phase;
    cycle_count_next = cycle_count;
    last_sent_next   = last_sent;
    lamp_next        = lamp;
    reducing_next    = reducing;
    cmd_pop          = 1'b0;
    res_push         = 1'b0;
    res_new          = '0;
    res_new.lamp_on   = lamp.lit;
    res_new.cur_phase = phase;
    if (go) begin
      unique case (cmd.kind)
        CMD_TICK: begin
          if (multi) begin
            phase_next       = total_wrap[PhaseW-1:0];
            cycle_count_next = cnt_inc;
            reducing_next    = 1'b1;
          end else begin
            phase_next       = ph_tick;
            cycle_count_next = cnt_tick;
            lamp_next        = lamp_tick;
            reducing_next    = 1'b0;
            cmd_pop          = 1'b1;
            res_push         = 1'b1;
            res_new.lamp_on   = lamp_tick.lit;
            res_new.cur_phase = ph_tick;
            if (tx_hit) begin
              last_sent_next   = cnt_tick;
              res_new.tx_valid = 1'b1;
              res_new.tx_phase = tx_wrap[PhaseW-1:0];
            end
          end
        end
        CMD_RX_OK: begin
          phase_next          = ph_rx;
          cycle_count_next    = cnt_rx;
          lamp_next           = lamp_rx;
          cmd_pop             = 1'b1;
          res_push            = 1'b1;
          res_new.lamp_on     = lamp_rx.lit;
          res_new.cur_phase   = ph_rx;
          res_new.rx_accepted = 1'b1;
          res_new.phase_step  = step_rx;
        end
        default: begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      cycle_count <= '0;
      last_sent   <= '1;
      lamp        <= '0;
      reducing    <= 1'b0;
    end else begin
      phase       <= phase_next;
      cycle_count <= cycle_count_next;
      last_sent   <= last_sent_next;
      lamp        <= lamp_next;
      reducing    <= reducing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[wr_sel] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel    <= 1'b0;
      rd_sel    <= 1'b0;
      out_count <= '0;
    end else begin
      if (res_push) wr_sel <= !wr_sel;
      if (do_pop)   rd_sel <= !rd_sel;
      unique case ({res_push, do_pop})
        2'b10:   out_count <= out_count + 1'b1;
        2'b01:   out_count <= out_count - 1'b1;
        default: out_count <= out_count;
      endcase
    end
  end

  assign empty = (out_count == 2'd0);
  assign res   = res_mem[rd_sel];

  a_reduce_holds_head: assert property (@(posedge clk) disable iff (rst)
    reducing |-> cmd_valid)
    else $error("phase reduction running without its tick at the queue head");

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= 2'd2)
    else $error("result queue overflow");

  a_tx_rx_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !(res_new.tx_valid && res_new.rx_accepted))
    else $error("transfer both sends and accepts a packet");

  a_step_limit: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_new.phase_step <= $signed({1'b0, cfg.max_step})) &&
                 (res_new.phase_step >= -$signed({1'b0, cfg.max_step})))
    else $error("phase correction exceeds step limit");

  a_pop_with_result: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> res_push)
    else $error("item consumed without a result");

endmodule

/* sv/flash_phase_sync_core.sv */
`timescale 1ns / 1ps
// flash_phase_sync_core: top level, configuration registers and wiring
// depends on fps_pkg, fps_front, fps_cmd_queue, fps_back

// Lamp flasher phase keeper. Items go in through push/full, results come out
// through empty/pop, one result per item in order. The block takes one item
// per clock while the input queue has room. The command queue stores the item
// at its transfer edge, and the phase unit then writes its result into the
// result buffer, from where it is taken through empty/pop. The input queue
// holds four items and the result buffer two; a full result buffer holds
// the phase unit back. So does a tick that finds the phase above a lowered
// cycle length and so wraps more than once: the phase unit then removes the
// extra wraps one at a time before it finishes that tick. Configuration
// writes take effect at once and belong to idle periods.

module flash_phase_sync_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation,
  input  logic [fps_pkg::ByteW-1:0]        elapsed_ms,
  input  logic [fps_pkg::ByteW-1:0]        rx_byte0,
  input  logic [fps_pkg::ByteW-1:0]        rx_byte1,
  input  logic [fps_pkg::ByteW-1:0]        rx_byte2,
  input  logic [fps_pkg::ByteW-1:0]        rx_byte3,
  output logic                             empty,
  input  logic                             pop,
  output logic                             lamp_on,
  output logic                             tx_valid,
  output logic [fps_pkg::PhaseW-1:0]       tx_phase,
  output logic [fps_pkg::PhaseW-1:0]       cur_phase,
  output logic                             rx_accepted,
  output logic signed [fps_pkg::StepW-1:0] phase_step,
  input  logic                             cfg_we,
  input  logic [fps_pkg::IdxW-1:0]         cfg_index,
  input  logic [fps_pkg::CfgW-1:0]         cfg_data
);
  import fps_pkg::*;

  cfg_t cfg;
  cmd_t cmd_in, cmd_head;
  logic q_push, q_full, q_empty, q_pop;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycle_length     <= RstCycleLength;
      cfg.led_on_time      <= RstLedOnTime;
      cfg.tx_window_start  <= RstTxWindowStart;
      cfg.tx_window_length <= RstTxWindowLen;
      cfg.tx_delay_comp    <= RstTxDelayComp;
      cfg.err_band         <= RstErrBand;
      cfg.max_step         <= RstMaxStep;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CYCLE_LENGTH:     cfg.cycle_length     <= cfg_data;
        REG_LED_ON_TIME:      cfg.led_on_time      <= cfg_data;
        REG_TX_WINDOW_START:  cfg.tx_window_start  <= cfg_data;
        REG_TX_WINDOW_LENGTH: cfg.tx_window_length <= cfg_data;
        REG_TX_DELAY_COMP:    cfg.tx_delay_comp    <= cfg_data[ByteW-1:0];
        REG_ERR_BAND:         cfg.err_band         <= cfg_data[ByteW-1:0];
        REG_MAX_STEP:         cfg.max_step         <= cfg_data[ByteW-1:0];
        default:              cfg                  <= cfg;
      endcase
    end
  end

  fps_front u_front (
    .cfg        (cfg),
    .push       (push),
    .operation  (operation),
    .elapsed_ms (elapsed_ms),
    .rx_byte0   (rx_byte0),
    .rx_byte1   (rx_byte1),
    .rx_byte2   (rx_byte2),
    .rx_byte3   (rx_byte3),
    .q_full     (q_full),
    .full       (full),
    .q_push     (q_push),
    .cmd        (cmd_in)
  );

  fps_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (cmd_head)
  );

  fps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!q_empty),
    .cmd       (cmd_head),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign lamp_on     = res.lamp_on;
  assign tx_valid    = res.tx_valid;
  assign tx_phase    = res.tx_phase;
  assign cur_phase   = res.cur_phase;
  assign rx_accepted = res.rx_accepted;
  assign phase_step  = res.phase_step;

endmodule
